@@ src/mprf_pkg.sv @@
// Package for the modem packet receive filter: types, codes and sizes.
// Used by every other file of the block but mprf_ram; depends on nothing.
package mprf_pkg;

  localparam int ADDR_MAX   = 64;
  localparam int ADDR_W     = $clog2(ADDR_MAX);
  localparam int PORT_COUNT = 65536;
  localparam int PORT_W     = 16;

  // Argument type ids
  localparam logic [31:0] TYPE_BOOL = 32'd1;
  localparam logic [31:0] TYPE_NUM  = 32'd3;
  localparam logic [31:0] TYPE_STR  = 32'd4;

  typedef enum logic [2:0] {
    OP_PKT   = 3'd0,
    OP_OPEN  = 3'd1,
    OP_CLOSE = 3'd2,
    OP_QUERY = 3'd3,
    OP_ADDR  = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    K_SENDER    = 4'd0,
    K_ACCEPTED  = 4'd1,
    K_ARG_TYPE  = 4'd2,
    K_ARG_BYTE  = 4'd3,
    K_DONE      = 4'd4,
    K_MALFORMED = 4'd5,
    K_DROPPED   = 4'd6,
    K_PORT_REPLY = 4'd7,
    K_BAD_PORT  = 4'd8
  } kind_t;

  // One input request as held in the processing stage
  typedef struct packed {
    logic [2:0]        opcode;
    logic [7:0]        data_byte;
    logic              end_of_packet;
    logic [PORT_W-1:0] port_number;
    logic [5:0]        addr_index;
  } item_t;

  // One result request
  typedef struct packed {
    kind_t              kind;
    logic [7:0]         byte_out;
    logic signed [31:0] value;
    logic [7:0]         arg_index;
    logic               flag;
    logic               last;
  } result_t;

  // Memory writes issued by the processing stage
  typedef struct packed {
    logic              map_we;
    logic [PORT_W-1:0] map_addr;
    logic              map_data;
    logic              own_we;
    logic [ADDR_W-1:0] own_addr;
    logic [7:0]        own_data;
  } mem_wr_t;

  function automatic result_t mk_res(kind_t k, logic [7:0] b, logic [31:0] v,
                                     logic [7:0] idx, logic f);
    result_t r;
    r.kind      = k;
    r.byte_out  = b;
    r.value     = signed'(v);
    r.arg_index = idx;
    r.flag      = f;
    r.last      = 1'b0;
    return r;
  endfunction

endpackage

@@ src/mprf_if.sv @@
// Handshake channels of the receive filter: input requests and results.
// Depends on mprf_pkg.
interface mprf_in_if;
  import mprf_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic [7:0]        data_byte;
  logic              end_of_packet;
  logic [PORT_W-1:0] port_number;
  logic [5:0]        addr_index;

  modport source (output valid, opcode, data_byte, end_of_packet, port_number,
                  addr_index, input ready);
  modport sink (input valid, opcode, data_byte, end_of_packet, port_number,
                addr_index, output ready);
endinterface

interface mprf_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         kind;
  logic [7:0]         byte_out;
  logic signed [31:0] value;
  logic [7:0]         arg_index;
  logic               flag;
  logic               last;

  modport source (output valid, kind, byte_out, value, arg_index, flag, last,
                  input ready);
  modport sink (input valid, kind, byte_out, value, arg_index, flag, last,
                output ready);
endinterface

@@ src/mprf_ram.sv @@
// Generic single-write, single-read synchronous RAM, registered read data.
// Standalone; no package needed.
module mprf_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ src/mprf_out_fifo.sv @@
// Four-entry result queue; takes up to two results a cycle, gives one while the output is ready.
// Depends on mprf_pkg and mprf_if.
module mprf_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [1:0]          push_n,
  input  mprf_pkg::result_t   push0,
  input  mprf_pkg::result_t   push1,
  output logic [2:0]          count,
  mprf_out_if.source          out_ch
);
  import mprf_pkg::*;

  result_t    mem [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;
  result_t    head;

  assign pop  = out_ch.valid && out_ch.ready;
  assign head = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + push_n;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_n} - {2'b0, pop};
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem[wp_r + 2'd1] <= push1;
    end
  end

  assign count            = cnt_r;
  assign out_ch.valid     = (cnt_r != 3'd0);
  assign out_ch.kind      = head.kind;
  assign out_ch.byte_out  = head.byte_out;
  assign out_ch.value     = head.value;
  assign out_ch.arg_index = head.arg_index;
  assign out_ch.flag      = head.flag;
  assign out_ch.last      = head.last;
endmodule

@@ src/mprf_parser.sv @@
// Processing stage: packet parser, port commands, memory prefetch and
// forwarding, and the port table clearing sweep. Depends on mprf_pkg.
module mprf_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [6:0]                    own_len,
  input  logic                          accept,
  input  mprf_pkg::item_t               in_item,
  input  logic                          map_q,
  input  logic [7:0]                    own_q,
  output logic [mprf_pkg::PORT_W-1:0]   map_raddr,
  output logic [mprf_pkg::ADDR_W-1:0]   own_raddr,
  output mprf_pkg::mem_wr_t             wr,
  output logic                          clearing,
  output logic [1:0]                    res_n,
  output mprf_pkg::result_t             res0,
  output mprf_pkg::result_t             res1
);
  import mprf_pkg::*;

  typedef enum logic [3:0] {
    PH_SLEN, PH_SBYTES, PH_HAS, PH_TLEN, PH_TBYTES, PH_PORT,
    PH_NARGS, PH_ATYPE, PH_ASLEN, PH_ABYTES, PH_SKIP
  } phase_t;

  phase_t      ph_r, ph_nxt;
  logic [31:0] fc_r, fc_nxt;     // bytes left in field
  logic [6:0]  fs_r, fs_nxt;     // byte within field / target position (sat)
  logic [31:0] fv_r, fv_nxt;     // gathered field value
  logic        tp_r, tp_nxt;
  logic        mm_r, mm_nxt;
  logic [31:0] al_r, al_nxt;     // arguments left
  logic [7:0]  ac_r, ac_nxt;     // argument counter

  logic        b_valid_r;
  item_t       b_r;
  logic        clr_r;
  logic [PORT_W-1:0] clr_addr_r;
  logic        map_fwd_r, map_fwd_d_r, own_fwd_r;
  logic [7:0]  own_fwd_d_r;

  logic        map_eff;
  logic [7:0]  own_eff;
  logic [31:0] gv;
  logic        gdone;
  logic        fin;
  logic        pflag;
  result_t     res [2];
  logic [1:0]  n;
  mem_wr_t     bw;

  assign map_eff = map_fwd_r ? map_fwd_d_r : map_q;
  assign own_eff = own_fwd_r ? own_fwd_d_r : own_q;
  assign gv      = fv_r | ({24'b0, b_r.data_byte} << {fs_r[1:0], 3'b000});
  assign gdone   = (fs_r[1:0] == 2'd3);

  // Next state and results of the request in the processing stage
  always_comb begin
    ph_nxt = ph_r; fc_nxt = fc_r; fs_nxt = fs_r; fv_nxt = fv_r;
    tp_nxt = tp_r; mm_nxt = mm_r; al_nxt = al_r; ac_nxt = ac_r;
    res[0] = '0; res[1] = '0; n = 2'd0;
    fin = 1'b0; pflag = 1'b0;
    bw = '0;
    if (b_valid_r) begin
      case (b_r.opcode)
        OP_OPEN, OP_CLOSE, OP_QUERY: begin
          if (b_r.port_number == '0) begin
            res[0] = mk_res(K_BAD_PORT, 8'd0, {16'd0, b_r.port_number}, 8'd0, 1'b0);
          end else begin
            pflag = (b_r.opcode == OP_OPEN) ? !map_eff : map_eff;
            bw.map_we   = (b_r.opcode != OP_QUERY);
            bw.map_addr = b_r.port_number;
            bw.map_data = (b_r.opcode == OP_OPEN);
            res[0] = mk_res(K_PORT_REPLY, 8'd0, {16'd0, b_r.port_number}, 8'd0,
                            pflag);
          end
          n = 2'd1;
        end
        OP_ADDR: begin
          bw.own_we   = 1'b1;
          bw.own_addr = b_r.addr_index[ADDR_W-1:0];
          bw.own_data = b_r.data_byte;
        end
        OP_PKT: begin
          // Gathering phases step by default
          fs_nxt = fs_r + 7'd1;
          fv_nxt = gv;
          case (ph_r)
            PH_SLEN: begin
              if (gdone) begin
                fs_nxt = '0; fv_nxt = '0;
                if (gv[31]) begin
                  res[n[0]] = mk_res(K_MALFORMED, 8'd0, 32'd0, 8'd0, 1'b0);
                  n = n + 2'd1; ph_nxt = PH_SKIP;
                end else if (gv == 32'd0) begin
                  ph_nxt = PH_HAS;
                end else begin
                  ph_nxt = PH_SBYTES; fc_nxt = gv;
                end
              end
            end
            PH_SBYTES: begin
              fs_nxt = '0; fv_nxt = '0;
              res[n[0]] = mk_res(K_SENDER, b_r.data_byte, 32'd0, 8'd0, 1'b0);
              n = n + 2'd1;
              fc_nxt = fc_r - 32'd1;
              if (fc_r == 32'd1) ph_nxt = PH_HAS;
            end
            PH_HAS: begin
              fs_nxt = '0; fv_nxt = '0;
              tp_nxt = (b_r.data_byte != 8'd0);
              ph_nxt = tp_nxt ? PH_TLEN : PH_PORT;
            end
            PH_TLEN: begin
              if (gdone) begin
                fs_nxt = '0; fv_nxt = '0;
                if (gv[31]) begin
                  res[n[0]] = mk_res(K_MALFORMED, 8'd0, 32'd0, 8'd0, 1'b0);
                  n = n + 2'd1; ph_nxt = PH_SKIP;
                end else begin
                  mm_nxt = (gv != {25'd0, own_len});
                  if (gv == 32'd0) begin
                    ph_nxt = PH_PORT;
                  end else begin
                    ph_nxt = PH_TBYTES; fc_nxt = gv;
                  end
                end
              end
            end
            PH_TBYTES: begin
              // Position saturates once past the address store
              fv_nxt = '0;
              fs_nxt = fs_r[6] ? fs_r : fs_r + 7'd1;
              if (!mm_r && (fs_r >= own_len || fs_r[6] || own_eff != b_r.data_byte))
                mm_nxt = 1'b1;
              fc_nxt = fc_r - 32'd1;
              if (fc_r == 32'd1) begin
                ph_nxt = PH_PORT; fs_nxt = '0;
              end
            end
            PH_PORT: begin
              if (gdone) begin
                fs_nxt = '0; fv_nxt = '0;
                if (gv[31:16] == 16'd0 && map_eff && !(tp_r && mm_r)) begin
                  res[n[0]] = mk_res(K_ACCEPTED, 8'd0, gv, 8'd0, 1'b0);
                  ph_nxt = PH_NARGS;
                end else begin
                  res[n[0]] = mk_res(K_DROPPED, 8'd0, 32'd0, 8'd0, 1'b0);
                  ph_nxt = PH_SKIP;
                end
                n = n + 2'd1;
              end
            end
            PH_NARGS: begin
              if (gdone) begin
                fs_nxt = '0; fv_nxt = '0;
                if (gv[31] || gv == 32'd0) begin
                  res[n[0]] = mk_res(K_DONE, 8'd0, 32'd0, 8'd0, 1'b0);
                  n = n + 2'd1; ph_nxt = PH_SKIP;
                end else begin
                  al_nxt = gv; ac_nxt = '0; ph_nxt = PH_ATYPE;
                end
              end
            end
            PH_ATYPE: begin
              if (gdone) begin
                fs_nxt = '0; fv_nxt = '0;
                res[n[0]] = mk_res(K_ARG_TYPE, 8'd0, gv, ac_r, 1'b0);
                n = n + 2'd1;
                if (gv == TYPE_BOOL) begin
                  ph_nxt = PH_ABYTES; fc_nxt = 32'd1;
                end else if (gv == TYPE_NUM) begin
                  ph_nxt = PH_ABYTES; fc_nxt = 32'd8;
                end else if (gv == TYPE_STR) begin
                  ph_nxt = PH_ASLEN;
                end else begin
                  fin = 1'b1;
                end
              end
            end
            PH_ASLEN: begin
              if (gdone) begin
                fs_nxt = '0; fv_nxt = '0;
                if (gv[31]) begin
                  res[n[0]] = mk_res(K_MALFORMED, 8'd0, 32'd0, 8'd0, 1'b0);
                  n = n + 2'd1; ph_nxt = PH_SKIP;
                end else if (gv == 32'd0) begin
                  fin = 1'b1;
                end else begin
                  ph_nxt = PH_ABYTES; fc_nxt = gv;
                end
              end
            end
            PH_ABYTES: begin
              fs_nxt = '0; fv_nxt = '0;
              res[n[0]] = mk_res(K_ARG_BYTE, b_r.data_byte, 32'd0, ac_r, 1'b0);
              n = n + 2'd1;
              fc_nxt = fc_r - 32'd1;
              if (fc_r == 32'd1) fin = 1'b1;
            end
            default: begin
              fs_nxt = '0; fv_nxt = '0; ph_nxt = PH_SKIP;
            end
          endcase
          // End of one argument
          if (fin) begin
            fs_nxt = '0; fv_nxt = '0;
            ac_nxt = (ac_r == 8'hff) ? ac_r : ac_r + 8'd1;
            al_nxt = al_r - 32'd1;
            if (al_r == 32'd1) begin
              res[n[0]] = mk_res(K_DONE, 8'd0, 32'd0, 8'd0, 1'b0);
              n = n + 2'd1; ph_nxt = PH_SKIP;
            end else begin
              ph_nxt = PH_ATYPE;
            end
          end
          // Packet end: truncation check, then restart
          if (b_r.end_of_packet) begin
            if (ph_nxt != PH_SKIP) begin
              res[n[0]] = mk_res(K_MALFORMED, 8'd0, 32'd0, 8'd0, 1'b0);
              n = n + 2'd1;
            end
            ph_nxt = PH_SLEN; fc_nxt = '0; fs_nxt = '0; fv_nxt = '0;
            tp_nxt = 1'b0; mm_nxt = 1'b0; al_nxt = '0; ac_nxt = '0;
          end
        end
        default: ;
      endcase
    end
    if (n == 2'd1) res[0].last = 1'b1;
    if (n == 2'd2) res[1].last = 1'b1;
  end

  // Write port: clearing sweep or processing stage
  always_comb begin
    wr = bw;
    if (clr_r) begin
      wr.map_we   = 1'b1;
      wr.map_addr = clr_addr_r;
      wr.map_data = 1'b0;
    end
  end

  // Prefetch for the request being accepted, seen after this stage's update
  assign map_raddr = (in_item.opcode == OP_OPEN || in_item.opcode == OP_CLOSE ||
                      in_item.opcode == OP_QUERY) ? in_item.port_number
                                                  : fv_nxt[PORT_W-1:0];
  assign own_raddr = fs_nxt[ADDR_W-1:0];

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_SLEN; fc_r <= '0; fs_r <= '0; fv_r <= '0;
      tp_r <= 1'b0; mm_r <= 1'b0; al_r <= '0; ac_r <= '0;
      b_valid_r  <= 1'b0;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      ph_r <= ph_nxt; fc_r <= fc_nxt; fs_r <= fs_nxt; fv_r <= fv_nxt;
      tp_r <= tp_nxt; mm_r <= mm_nxt; al_r <= al_nxt; ac_r <= ac_nxt;
      b_valid_r <= accept;
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == PORT_W'(PORT_COUNT - 1)) clr_r <= 1'b0;
      end
    end
  end

  // Request and forwarding payload
  always_ff @(posedge clk) begin
    b_r         <= in_item;
    map_fwd_r   <= wr.map_we && (wr.map_addr == map_raddr);
    map_fwd_d_r <= wr.map_data;
    own_fwd_r   <= wr.own_we && (wr.own_addr == own_raddr);
    own_fwd_d_r <= wr.own_data;
  end

  assign clearing = clr_r;
  assign res_n    = n;
  assign res0     = res[0];
  assign res1     = res[1];
endmodule

@@ src/modem_packet_receive_filter_top.sv @@
// Top level of the modem packet receive filter.
// Depends on mprf_pkg, mprf_if, mprf_ram, mprf_out_fifo and mprf_parser.

// One request is taken per clock cycle while input is ready and processed in the following
// cycle, which reads the port table and own-address store prefetched at acceptance
// (registered memory reads, writes forwarded). Each request gives at most two
// results, which wait in a four-entry queue; input is held off while that queue
// could not take two more, and while the 65536-entry port table is cleared after
// reset, one entry per cycle; configuration writes are taken throughout.
module modem_packet_receive_filter_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_data,
  mprf_in_if.sink    in_ch,
  mprf_out_if.source out_ch
);
  import mprf_pkg::*;

  logic [6:0]        own_addr_len_r;
  logic [6:0]        own_len;
  logic              accept;
  item_t             in_item;
  logic              map_q;
  logic [7:0]        own_q;
  logic [PORT_W-1:0] map_raddr;
  logic [ADDR_W-1:0] own_raddr;
  mem_wr_t           wr;
  logic              clearing;
  logic [1:0]        res_n;
  result_t           res0, res1;
  logic [2:0]        fifo_count;

  // Own address length register, clamped to the store size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_len_r <= '0;
    end else if (cfg_we) begin
      own_addr_len_r <= cfg_data;
    end
  end
  assign own_len = (own_addr_len_r > 7'(ADDR_MAX)) ? 7'(ADDR_MAX) : own_addr_len_r;

  assign in_item.opcode        = in_ch.opcode;
  assign in_item.data_byte     = in_ch.data_byte;
  assign in_item.end_of_packet = in_ch.end_of_packet;
  assign in_item.port_number   = in_ch.port_number;
  assign in_item.addr_index    = in_ch.addr_index;

  assign in_ch.ready = !clearing && (({1'b0, fifo_count} + {2'b0, res_n}) <= 4'd2);
  assign accept      = in_ch.valid && in_ch.ready;

  mprf_ram #(.DEPTH(PORT_COUNT), .WIDTH(1)) u_port_map (
    .clk   (clk),
    .we    (wr.map_we),
    .waddr (wr.map_addr),
    .wdata (wr.map_data),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  mprf_ram #(.DEPTH(ADDR_MAX), .WIDTH(8)) u_own_addr (
    .clk   (clk),
    .we    (wr.own_we),
    .waddr (wr.own_addr),
    .wdata (wr.own_data),
    .raddr (own_raddr),
    .rdata (own_q)
  );

  mprf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .own_len   (own_len),
    .accept    (accept),
    .in_item   (in_item),
    .map_q     (map_q),
    .own_q     (own_q),
    .map_raddr (map_raddr),
    .own_raddr (own_raddr),
    .wr        (wr),
    .clearing  (clearing),
    .res_n     (res_n),
    .res0      (res0),
    .res1      (res1)
  );

  mprf_out_fifo u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (res_n),
    .push0  (res0),
    .push1  (res1),
    .count  (fifo_count),
    .out_ch (out_ch)
  );
endmodule

@@ bench/tb_modem_packet_receive_filter_top.sv @@
// Self-checking bench for modem_packet_receive_filter_top: directed table, then random packets.
// Depends on mprf_pkg, mprf_if and the block's RTL; expected results come from a local deframer.
`timescale 1ns / 100ps

module tb_modem_packet_receive_filter_top;
  import mprf_pkg::*;

  localparam int CYCLE_LIMIT  = 1500000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int SETTLE       = 10;

  // Parse phases of the local deframer
  typedef enum int {
    PH_SLEN, PH_SBYTES, PH_HAS, PH_TLEN, PH_TBYTES, PH_PORT,
    PH_NARGS, PH_ATYPE, PH_ASLEN, PH_ABYTES, PH_SKIP
  } phase_e;

  // One directed row: the request and, where obvious, its single result
  typedef struct {
    item_t   req;
    logic    typed;
    result_t res;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [6:0] cfg_data;

  mprf_in_if  in_ch();
  mprf_out_if out_ch();

  modem_packet_receive_filter_top DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .in_ch   (in_ch),
    .out_ch  (out_ch)
  );

  // Deframer mirror state
  phase_e      phase;
  logic [31:0] fcount, fshift, fvalue, port_latched, args_left, arg_kind;
  logic        tgt_present, tgt_mismatch;
  logic [7:0]  arg_num;
  bit          port_open [PORT_COUNT];
  logic [7:0]  own_addr [ADDR_MAX];
  logic [6:0]  own_len_reg;

  result_t     step_res [2];
  int          step_n;
  result_t     pending_results [$];
  logic [7:0]  pkt_bytes [$];

  int errors, accepted_reqs, checked_results, cycles, malformed_seen, accepted_pkts;

  // Clock and timeout
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles,
               pending_results.size());
      $display("modem_packet_receive_filter_top regression: fail");
      $finish;
    end
  end

  function automatic int own_len();
    return (own_len_reg > ADDR_MAX) ? ADDR_MAX : int'(own_len_reg);
  endfunction

  function automatic void emit(kind_t k, logic [7:0] b, logic [31:0] v, logic [7:0] idx,
                               logic f);
    if (step_n >= 2) return;
    step_res[step_n].kind      = k;
    step_res[step_n].byte_out  = b;
    step_res[step_n].value     = signed'(v);
    step_res[step_n].arg_index = idx;
    step_res[step_n].flag      = f;
    step_res[step_n].last      = 1'b0;
    step_n++;
  endfunction

  function automatic void enter(phase_e p);
    phase  = p;
    fshift = 0;
    fvalue = 0;
  endfunction

  function automatic void restart_packet();
    enter(PH_SLEN);
    fcount       = 0;
    tgt_present  = 0;
    tgt_mismatch = 0;
    port_latched = 0;
    args_left    = 0;
    arg_kind     = 0;
    arg_num      = 0;
  endfunction

  // Little-endian 32-bit field collection; true once four bytes are in
  function automatic bit collect(logic [7:0] b);
    fvalue = fvalue | (32'(b) << fshift[4:0]);
    fshift = fshift + 8;
    return fshift >= 32;
  endfunction

  function automatic void close_arg();
    if (arg_num < 8'd255) arg_num++;
    args_left--;
    if (args_left == 0) begin
      emit(K_DONE, 0, 0, 0, 0);
      enter(PH_SKIP);
    end else begin
      enter(PH_ATYPE);
    end
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    logic [31:0] v;
    case (phase)
      PH_SLEN: if (collect(b)) begin
        v = fvalue;
        if (v[31]) begin
          emit(K_MALFORMED, 0, 0, 0, 0);
          enter(PH_SKIP);
        end else if (v == 0) begin
          enter(PH_HAS);
        end else begin
          enter(PH_SBYTES);
          fcount = v;
        end
      end
      PH_SBYTES: begin
        emit(K_SENDER, b, 0, 0, 0);
        fcount--;
        if (fcount == 0) enter(PH_HAS);
      end
      PH_HAS: begin
        tgt_present = (b != 0);
        enter(tgt_present ? PH_TLEN : PH_PORT);
      end
      PH_TLEN: if (collect(b)) begin
        v = fvalue;
        if (v[31]) begin
          emit(K_MALFORMED, 0, 0, 0, 0);
          enter(PH_SKIP);
        end else begin
          tgt_mismatch = (v != own_len());
          if (v == 0) enter(PH_PORT);
          else begin
            enter(PH_TBYTES);
            fcount = v;
          end
        end
      end
      PH_TBYTES: begin
        // fshift counts the target byte position here
        if (!tgt_mismatch) begin
          if (fshift >= own_len() || fshift >= ADDR_MAX) tgt_mismatch = 1;
          else if (own_addr[fshift[5:0]] != b) tgt_mismatch = 1;
        end
        fshift++;
        fcount--;
        if (fcount == 0) enter(PH_PORT);
      end
      PH_PORT: if (collect(b)) begin
        port_latched = fvalue;
        if (port_latched < PORT_COUNT && port_open[port_latched[15:0]] &&
            !(tgt_present && tgt_mismatch)) begin
          emit(K_ACCEPTED, 0, port_latched, 0, 0);
          enter(PH_NARGS);
        end else begin
          emit(K_DROPPED, 0, 0, 0, 0);
          enter(PH_SKIP);
        end
      end
      PH_NARGS: if (collect(b)) begin
        v = fvalue;
        if (v[31] || v == 0) begin
          emit(K_DONE, 0, 0, 0, 0);
          enter(PH_SKIP);
        end else begin
          args_left = v;
          arg_num   = 0;
          enter(PH_ATYPE);
        end
      end
      PH_ATYPE: if (collect(b)) begin
        v = fvalue;
        emit(K_ARG_TYPE, 0, v, arg_num, 0);
        if (v == TYPE_BOOL) begin
          arg_kind = v;
          enter(PH_ABYTES);
          fcount = 1;
        end else if (v == TYPE_NUM) begin
          arg_kind = v;
          enter(PH_ABYTES);
          fcount = 8;
        end else if (v == TYPE_STR) begin
          arg_kind = v;
          enter(PH_ASLEN);
        end else begin
          arg_kind = 0;
          close_arg();
        end
      end
      PH_ASLEN: if (collect(b)) begin
        v = fvalue;
        if (v[31]) begin
          emit(K_MALFORMED, 0, 0, 0, 0);
          enter(PH_SKIP);
        end else if (v == 0) begin
          close_arg();
        end else begin
          enter(PH_ABYTES);
          fcount = v;
        end
      end
      PH_ABYTES: begin
        emit(K_ARG_BYTE, b, 0, arg_num, 0);
        fcount--;
        if (fcount == 0) close_arg();
      end
      default: enter(PH_SKIP);
    endcase
  endfunction

  // Expected results of one accepted request, left in step_res
  function automatic void deframe_step(item_t r);
    logic f;
    step_n = 0;
    case (r.opcode)
      OP_OPEN, OP_CLOSE, OP_QUERY: begin
        if (r.port_number == 0) begin
          emit(K_BAD_PORT, 0, 32'(r.port_number), 0, 0);
        end else begin
          if (r.opcode == OP_OPEN) begin
            f = !port_open[r.port_number];
            port_open[r.port_number] = 1;
          end else if (r.opcode == OP_CLOSE) begin
            f = port_open[r.port_number];
            port_open[r.port_number] = 0;
          end else begin
            f = port_open[r.port_number];
          end
          emit(K_PORT_REPLY, 0, 32'(r.port_number), 0, f);
        end
      end
      OP_ADDR: own_addr[r.addr_index] = r.data_byte;
      OP_PKT: begin
        parse_byte(r.data_byte);
        if (r.end_of_packet) begin
          if (phase != PH_SKIP) emit(K_MALFORMED, 0, 0, 0, 0);
          restart_packet();
        end
      end
      default: ;
    endcase
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  // Send side: bursts with random gaps between them
  int burst_left;

  task automatic send_req(item_t r, logic typed, result_t typed_res);
    int gap;
    @(negedge clk);
    in_ch.valid         = 1'b1;
    in_ch.opcode        = r.opcode;
    in_ch.data_byte     = r.data_byte;
    in_ch.end_of_packet = r.end_of_packet;
    in_ch.port_number   = r.port_number;
    in_ch.addr_index    = r.addr_index;
    do @(posedge clk); while (!in_ch.ready);
    accepted_reqs++;
    deframe_step(r);
    if (typed) pending_results.insert(pending_results.size(), typed_res);
    else for (int i = 0; i < step_n; i++)
      pending_results.insert(pending_results.size(), step_res[i]);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 24);
      gap = $urandom_range(1, 7);
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_plain(item_t r);
    result_t none;
    none = '0;
    send_req(r, 1'b0, none);
  endtask

  // Receive side: stall pattern picked anew whenever the low byte of stall_tick is zero
  int stall_mode, stall_tick;

  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[7:0] == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 1) == 1);
      2: out_ch.ready <= (stall_tick[1:0] == 2'd0);
      default: out_ch.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Result check against the oldest expectation
  task automatic report(string field, longint expv, longint gotv);
    errors++;
    $display("%0t: mismatch in %s: expected %0d, got %0d", $time, field, expv, gotv);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got kind %0d", $time,
                 out_ch.kind);
      end else begin
        e = pending_results.pop_front();
        checked_results++;
        if (e.kind == K_MALFORMED) malformed_seen++;
        if (e.kind == K_ACCEPTED) accepted_pkts++;
        if (out_ch.kind !== e.kind) report("kind", e.kind, out_ch.kind);
        if (out_ch.byte_out !== e.byte_out) report("byte_out", e.byte_out, out_ch.byte_out);
        if (out_ch.value !== e.value) report("value", e.value, out_ch.value);
        if (out_ch.arg_index !== e.arg_index)
          report("arg_index", e.arg_index, out_ch.arg_index);
        if (out_ch.flag !== e.flag) report("flag", e.flag, out_ch.flag);
        if (out_ch.last !== e.last) report("last", e.last, out_ch.last);
      end
    end
  end

  task automatic write_own_len(logic [6:0] v);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we      = 1'b0;
    own_len_reg = v;
  endtask

  // Withdraw the last request, then wait until every expected result is out
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic item_t mk_item(op_t op, logic [7:0] b, logic eop, logic [15:0] pn,
                                    logic [5:0] ai);
    item_t r;
    r.opcode        = op;
    r.data_byte     = b;
    r.end_of_packet = eop;
    r.port_number   = pn;
    r.addr_index    = ai;
    return r;
  endfunction

  function automatic void add_byte(logic [7:0] b);
    pkt_bytes.insert(pkt_bytes.size(), b);
  endfunction

  function automatic void add32(logic [31:0] v);
    for (int i = 0; i < 4; i++) add_byte(v[8*i +: 8]);
  endfunction

  function automatic logic [31:0] pick_port();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h0001_0000;
      2: return 32'h8000_0000 | $urandom;
      3: return 32'd65535;
      4: return 32'd1;
      5: return 32'd100;
      default: return 32'd7;
    endcase
  endfunction

  function automatic logic [15:0] pick_op_port();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 16'd0;
      2: return 16'd65535;
      3: return 16'd1;
      4: return 16'd100;
      default: return 16'd7;
    endcase
  endfunction

  // Builds one packet into pkt_bytes; broken ones may get a bad length or count,
  // a cut or trailing bytes
  function automatic void build_packet(bit broken);
    int n, t, sel;
    bit flaw;
    pkt_bytes.delete();
    sel = broken ? $urandom_range(0, 7) : 8;
    n = $urandom_range(0, 3);
    if (sel == 0) add32(32'h8000_0000 | $urandom);
    else begin
      add32(n);
      repeat (n) add_byte(8'($urandom));
    end
    if ($urandom_range(0, 1)) begin
      add_byte(8'($urandom_range(1, 255)));
      if (sel == 1) add32(32'h8000_0000 | $urandom);
      else if ($urandom_range(0, 3) != 0) begin
        add32(own_len());
        flaw = ($urandom_range(0, 4) == 0);
        t = $urandom_range(0, own_len() > 0 ? own_len() - 1 : 0);
        for (int i = 0; i < own_len(); i++)
          add_byte((flaw && i == t) ? own_addr[i] ^ 8'h5a : own_addr[i]);
      end else begin
        n = $urandom_range(0, 3);
        add32(n);
        repeat (n) add_byte(8'($urandom));
      end
    end else begin
      add_byte(8'h00);
    end
    add32(pick_port());
    if (sel == 2) add32(32'h8000_0000 | $urandom);
    else begin
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
      add32(n);
      repeat (n) begin
        case ($urandom_range(0, 6))
          0: t = 0;
          1: t = 1;
          2: t = 3;
          3, 4: t = 4;
          5: t = 2;
          default: t = $urandom;
        endcase
        add32(t);
        if (t == 1) add_byte(8'($urandom));
        else if (t == 3) repeat (8) add_byte(8'($urandom));
        else if (t == 4) begin
          if (sel == 3) add32(32'hffff_ffff - $urandom_range(0, 9));
          else begin
            n = $urandom_range(0, 5);
            add32(n);
            repeat (n) add_byte(8'($urandom));
          end
        end
      end
    end
    if (sel == 4 || sel == 5) begin
      n = $urandom_range(1, pkt_bytes.size());
      while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
    end else if (sel == 6) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
    end
  endfunction

  task automatic send_packet(output int sent);
    sent = pkt_bytes.size();
    foreach (pkt_bytes[i])
      send_plain(mk_item(OP_PKT, pkt_bytes[i], i == pkt_bytes.size() - 1, $urandom,
                         $urandom));
  endtask

  task automatic random_phase(int count);
    int done_n, sent, r;
    done_n = 0;
    while (done_n < count) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        build_packet(0);
        send_packet(sent);
        done_n += sent;
      end else if (r < 68) begin
        build_packet(1);
        send_packet(sent);
        done_n += sent;
      end else if (r < 82) begin
        send_plain(mk_item(op_t'($urandom_range(OP_OPEN, OP_QUERY)), $urandom, $urandom,
                           pick_op_port(), $urandom));
        done_n++;
      end else if (r < 88) begin
        send_plain(mk_item(OP_ADDR, $urandom, $urandom, $urandom, $urandom));
      end else if (r < 92) begin
        send_plain(mk_item(op_t'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                           $urandom));
      end else begin
        send_plain(mk_item(OP_PKT, $urandom, $urandom_range(0, 1), $urandom, $urandom));
        done_n++;
      end
    end
  endtask

  // Directed table
  row_t rows [$];

  function automatic void add_row(item_t r, logic typed, kind_t k, logic [31:0] v,
                                  logic f);
    row_t w;
    w.req = r;
    w.typed = typed;
    w.res = '0;
    w.res.kind  = k;
    w.res.value = signed'(v);
    w.res.flag  = f;
    w.res.last  = 1'b1;
    rows.insert(rows.size(), w);
  endfunction

  initial begin
    logic [7:0] pb [$];
    logic [6:0] cfg_set [5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.data_byte = '0;
    in_ch.end_of_packet = 1'b0;
    in_ch.port_number = '0;
    in_ch.addr_index = '0;
    out_ch.ready = 1'b0;
    errors = 0; accepted_reqs = 0; checked_results = 0; cycles = 0;
    malformed_seen = 0; accepted_pkts = 0;
    stall_mode = 0; stall_tick = 0; burst_left = 0;
    own_len_reg = 0;
    foreach (port_open[i]) port_open[i] = 0;
    foreach (own_addr[i]) own_addr[i] = 0;
    restart_packet();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // First setting and a fully written own address, so no target read sees an unwritten byte
    write_own_len(7'd64);
    for (int i = 0; i < ADDR_MAX; i++)
      send_plain(mk_item(OP_ADDR, $urandom, 1'b0, 16'd0, 6'(i)));

    // Port operations at the edges, unused opcodes, a truncated one-byte packet, then a minimal packet to port 7
    add_row(mk_item(OP_OPEN, 8'h00, 1'b0, 16'd0, 6'd0), 1, K_BAD_PORT, 0, 0);
    add_row(mk_item(OP_QUERY, 8'hff, 1'b1, 16'hffff, 6'd63), 1, K_PORT_REPLY, 65535, 0);
    add_row(mk_item(OP_OPEN, 8'h00, 1'b0, 16'hffff, 6'd0), 1, K_PORT_REPLY, 65535, 1);
    add_row(mk_item(OP_OPEN, 8'h00, 1'b0, 16'hffff, 6'd0), 1, K_PORT_REPLY, 65535, 0);
    add_row(mk_item(OP_CLOSE, 8'h00, 1'b0, 16'hffff, 6'd0), 1, K_PORT_REPLY, 65535, 1);
    add_row(mk_item(OP_CLOSE, 8'h00, 1'b0, 16'd0, 6'd0), 1, K_BAD_PORT, 0, 0);
    add_row(mk_item(OP_OPEN, 8'h00, 1'b0, 16'd7, 6'd0), 1, K_PORT_REPLY, 7, 1);
    add_row(mk_item(OP_OPEN, 8'h00, 1'b0, 16'd1, 6'd0), 1, K_PORT_REPLY, 1, 1);
    add_row(mk_item(op_t'(3'd5), 8'hff, 1'b1, 16'hffff, 6'd63), 0, K_DONE, 0, 0);
    add_row(mk_item(op_t'(3'd7), 8'hff, 1'b1, 16'hffff, 6'd63), 0, K_DONE, 0, 0);
    add_row(mk_item(OP_PKT, 8'h00, 1'b1, 16'd0, 6'd0), 1, K_MALFORMED, 0, 0);
    pb = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00,
           8'h00, 8'h00, 8'h00, 8'h00};
    foreach (pb[i])
      add_row(mk_item(OP_PKT, pb[i], i == pb.size() - 1, 16'd0, 6'd0), 0, K_DONE, 0, 0);
    foreach (rows[i]) send_req(rows[i].req, rows[i].typed, rows[i].res);

    // Random traffic over several address lengths, including 0 and values above the store size
    cfg_set = '{7'd64, 7'd0, 7'd127, 7'd3, 7'($urandom_range(1, 63))};
    foreach (cfg_set[p]) begin
      drain();
      write_own_len(cfg_set[p]);
      if (p == 1) send_plain(mk_item(OP_OPEN, 8'h00, 1'b0, 16'd100, 6'd0));
      random_phase(RANDOM_ITEMS / 5);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    drain();
    $display("covered %0d requests and %0d checked results (%0d accepted packets,",
             accepted_reqs, checked_results, accepted_pkts);
    $display("  %0d malformed) over five address lengths, with send gaps and receive stalls",
             malformed_seen);
    if (errors == 0) begin
      $display("modem_packet_receive_filter_top regression: pass");
    end else begin
      $display("%0d mismatches", errors);
      $display("modem_packet_receive_filter_top regression: fail");
    end
    $finish;
  end

endmodule
